>>> design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and codes of the buddy page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	// sizes of the page store and of the free lists
	localparam int NUM_PAGES  = 65536;
	localparam int ORDER_CNT  = 12;
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int LINK_W     = PAGE_W + 1;
	localparam int EXT_W      = PAGE_W + 2;
	localparam int HEAD_W     = $clog2(ORDER_CNT);
	localparam int ORD_W      = 4;
	localparam int ADDR_W     = 40;
	localparam int CNT_W      = 17;
	localparam int PAGE_SHIFT = 12;
	localparam int OFF_W      = ADDR_W - PAGE_SHIFT;
	localparam int BLK        = 1 << (ORDER_CNT - 1);
	localparam int INFO_W     = 2 + ORD_W;

	// empty link: top bit set means outside the page store
	localparam logic [LINK_W-1:0] NIL = '1;

	// page record states
	localparam logic [1:0] PG_FREE  = 2'd0;
	localparam logic [1:0] PG_ALLOC = 2'd1;
	localparam logic [1:0] PG_RSVD  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_RAM_BASE   = 2'd0;
	localparam logic [1:0] CFG_RAM_PAGES  = 2'd1;
	localparam logic [1:0] CFG_FIRST_FREE = 2'd2;

	// reset values of the configuration registers
	localparam logic [ADDR_W-1:0] RAM_BASE_RST   = 40'h0080000000;
	localparam logic [CNT_W-1:0]  RAM_PAGES_RST  = 17'd65536;
	localparam logic [CNT_W-1:0]  FIRST_FREE_RST = 17'd0;

	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_BAD   = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_BAD_ORDER    = 4'd1,
		ST_NO_MEM       = 4'd2,
		ST_MISALIGNED   = 4'd3,
		ST_RANGE        = 4'd4,
		ST_ALREADY_FREE = 4'd5,
		ST_RESERVED     = 4'd6,
		ST_NO_POOL      = 4'd7,
		ST_NO_INIT      = 4'd8
	} status_t;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DECODE,
		OP_SWEEP,
		OP_INIT_END,
		OP_A_HEAD,
		OP_PUSH_SPLIT,
		OP_PUSH_FREE,
		OP_PUSH_LINK,
		OP_A_FIN,
		OP_F_CHK,
		OP_F_BUD,
		OP_F_UNLINK,
		OP_F_CLR,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t code;
	} bpa_cmd_t;

	typedef struct packed {
		req_t req;
		logic pool_ready;
		logic init_err;
		logic ord_bad;
		logic none_found;
		logic misaligned;
		logic out_of_range;
		logic rd_free;
		logic rd_alloc;
		logic cur_gt_ord;
		logic cur_top;
		logic bud_oob;
		logic bud_match;
		logic sweep_last;
		logic out_free;
	} bpa_stat_t;

endpackage

`default_nettype wire

>>> design/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> design/bpa_dpath.sv
// ----------------------------------------------------------------------------
// bpa_dpath
// Datapath: page record memories, free-list heads, config and result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpa_dpath
	import bpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bpa_cmd_t          cmd,
	output bpa_stat_t              stat,
	input  wire logic [1:0]        in_type,
	input  wire logic [ORD_W-1:0]  in_order,
	input  wire logic [ADDR_W-1:0] in_addr,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [ADDR_W-1:0] cfg_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [3:0]             out_status,
	output logic [ADDR_W-1:0]      out_addr
);

	logic [ADDR_W-1:0] ram_base_q;
	logic [CNT_W-1:0]  ram_pages_q;
	logic [CNT_W-1:0]  first_free_q;

	req_t              req_q;
	logic [ORD_W-1:0]  req_order_q;
	logic [ADDR_W-1:0] req_addr_q;

	logic [LINK_W-1:0] head_q [ORDER_CNT];
	logic              pool_ready_q;
	logic [PAGE_W-1:0] idx_q;
	logic [PAGE_W-1:0] tgt_q;
	logic [ORD_W-1:0]  cur_q;
	logic [LINK_W-1:0] link_q;
	logic [PAGE_W-1:0] sw_q;

	logic              out_valid_q;
	logic [3:0]        out_status_q;
	logic [ADDR_W-1:0] out_addr_q;

	// memory ports
	logic              info_we, next_we, prev_we;
	logic [PAGE_W-1:0] info_waddr, next_waddr, prev_waddr, rd_addr;
	logic [INFO_W-1:0] info_wdata, info_rdata;
	logic [LINK_W-1:0] next_wdata, next_rdata, prev_wdata, prev_rdata;

	// derived values
	logic [LINK_W-1:0] total;
	logic [EXT_W-1:0]  total_ext, start, sw_ext, last_blk;
	logic              blk_here;
	logic [LINK_W-1:0] sw_next, sw_prev;
	logic [ORD_W-1:0]  found;
	logic              none;
	logic [ADDR_W-1:0] diff;
	logic [OFF_W-1:0]  off;
	logic [ORD_W-1:0]  cur_dn;
	logic [PAGE_W-1:0] split_b, bud;
	logic [LINK_W-1:0] old_head_dn, old_head;
	logic              free_out_ok;

	bpa_ram #(.WIDTH(INFO_W), .DEPTH(NUM_PAGES)) u_info (
		.clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
		.raddr(rd_addr), .rdata(info_rdata)
	);

	bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(rd_addr), .rdata(next_rdata)
	);

	bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(rd_addr), .rdata(prev_rdata)
	);

	// pool geometry
	always_comb begin
		total     = (ram_pages_q > CNT_W'(NUM_PAGES)) ? LINK_W'(NUM_PAGES)
		                                              : LINK_W'(ram_pages_q);
		total_ext = EXT_W'(total);
		start     = (EXT_W'(first_free_q) + EXT_W'(BLK - 1)) & ~EXT_W'(BLK - 1);
		last_blk  = (total_ext & ~EXT_W'(BLK - 1)) - EXT_W'(BLK);
		sw_ext    = EXT_W'(sw_q);
		blk_here  = (sw_q[ORDER_CNT-2:0] == '0) && (sw_ext >= start) &&
		            (sw_ext + EXT_W'(BLK) <= total_ext);
		sw_next   = (sw_ext == start) ? NIL : LINK_W'(sw_ext - EXT_W'(BLK));
		sw_prev   = (sw_ext + EXT_W'(2 * BLK) <= total_ext) ?
		            LINK_W'(sw_ext + EXT_W'(BLK)) : NIL;
	end

	// smallest non-empty order at or above the request
	always_comb begin
		found = '0;
		none  = 1'b1;
		for (int o = ORDER_CNT - 1; o >= 0; o--) begin
			if (ORD_W'(o) >= req_order_q && !head_q[o][LINK_W-1]) begin
				found = ORD_W'(o);
				none  = 1'b0;
			end
		end
	end

	// free address checks and buddy arithmetic
	always_comb begin
		diff        = req_addr_q - ram_base_q;
		off         = diff[ADDR_W-1:PAGE_SHIFT];
		free_out_ok = (req_addr_q >= ram_base_q) && (off < OFF_W'(total));
		cur_dn      = cur_q - ORD_W'(1);
		split_b     = idx_q + (PAGE_W'(1) << cur_dn);
		bud         = idx_q ^ (PAGE_W'(1) << cur_q);
		old_head_dn = head_q[cur_dn[HEAD_W-1:0]];
		old_head    = head_q[cur_q[HEAD_W-1:0]];
	end

	// status toward the controller
	always_comb begin
		stat.req          = req_q;
		stat.pool_ready   = pool_ready_q;
		stat.init_err     = (start + EXT_W'(BLK)) > total_ext;
		stat.ord_bad      = (5'(req_order_q) >= 5'(ORDER_CNT));
		stat.none_found   = none;
		stat.misaligned   = |req_addr_q[PAGE_SHIFT-1:0];
		stat.out_of_range = !free_out_ok;
		stat.rd_free      = (info_rdata[INFO_W-1 -: 2] == PG_FREE);
		stat.rd_alloc     = (info_rdata[INFO_W-1 -: 2] == PG_ALLOC);
		stat.cur_gt_ord   = cur_q > req_order_q;
		stat.cur_top      = (5'(cur_q) >= 5'(ORDER_CNT - 1));
		stat.bud_oob      = LINK_W'(bud) >= total;
		stat.bud_match    = (info_rdata[INFO_W-1 -: 2] == PG_FREE) &&
		                    (info_rdata[ORD_W-1:0] == cur_q);
		stat.sweep_last   = &sw_q;
		stat.out_free     = !out_valid_q || out_ready;
	end

	// memory write and read selection
	always_comb begin
		info_we    = 1'b0;
		info_waddr = idx_q;
		info_wdata = {PG_RSVD, ORD_W'(0)};
		next_we    = 1'b0;
		next_waddr = idx_q;
		next_wdata = NIL;
		prev_we    = 1'b0;
		prev_waddr = idx_q;
		prev_wdata = NIL;
		rd_addr    = bud;
		case (cmd.op)
			OP_DECODE: begin
				rd_addr = (req_q == REQ_ALLOC) ? head_q[found[HEAD_W-1:0]][PAGE_W-1:0]
				                               : off[PAGE_W-1:0];
			end
			OP_SWEEP: begin
				info_we    = 1'b1;
				next_we    = 1'b1;
				prev_we    = 1'b1;
				info_waddr = sw_q;
				next_waddr = sw_q;
				prev_waddr = sw_q;
				if (blk_here) begin
					info_wdata = {PG_FREE, ORD_W'(ORDER_CNT - 1)};
					next_wdata = sw_next;
					prev_wdata = sw_prev;
				end
			end
			OP_A_HEAD: begin
				prev_we    = !next_rdata[LINK_W-1];
				prev_waddr = next_rdata[PAGE_W-1:0];
			end
			OP_PUSH_SPLIT: begin
				info_we    = 1'b1;
				next_we    = 1'b1;
				prev_we    = 1'b1;
				info_waddr = split_b;
				next_waddr = split_b;
				prev_waddr = split_b;
				info_wdata = {PG_FREE, cur_dn};
				next_wdata = old_head_dn;
			end
			OP_PUSH_FREE: begin
				info_we    = 1'b1;
				next_we    = 1'b1;
				prev_we    = 1'b1;
				info_wdata = {PG_FREE, cur_q};
				next_wdata = old_head;
			end
			OP_PUSH_LINK: begin
				prev_we    = !link_q[LINK_W-1];
				prev_waddr = link_q[PAGE_W-1:0];
				prev_wdata = LINK_W'(tgt_q);
			end
			OP_A_FIN: begin
				info_we    = 1'b1;
				next_we    = 1'b1;
				prev_we    = 1'b1;
				info_wdata = {PG_ALLOC, req_order_q};
			end
			OP_F_UNLINK: begin
				// splice the buddy out of its list
				next_we    = (prev_rdata != NIL) && !prev_rdata[LINK_W-1];
				next_waddr = prev_rdata[PAGE_W-1:0];
				next_wdata = next_rdata;
				prev_we    = !next_rdata[LINK_W-1];
				prev_waddr = next_rdata[PAGE_W-1:0];
				prev_wdata = prev_rdata;
			end
			OP_F_CLR: begin
				info_we    = 1'b1;
				next_we    = 1'b1;
				prev_we    = 1'b1;
				info_waddr = tgt_q;
				next_waddr = tgt_q;
				prev_waddr = tgt_q;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_base_q   <= RAM_BASE_RST;
			ram_pages_q  <= RAM_PAGES_RST;
			first_free_q <= FIRST_FREE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RAM_BASE:   ram_base_q   <= cfg_data;
				CFG_RAM_PAGES:  ram_pages_q  <= cfg_data[CNT_W-1:0];
				CFG_FIRST_FREE: first_free_q <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// free-list heads and pool flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int o = 0; o < ORDER_CNT; o++) begin
				head_q[o] <= NIL;
			end
			pool_ready_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_INIT_END: begin
					for (int o = 0; o < ORDER_CNT; o++) begin
						head_q[o] <= NIL;
					end
					head_q[ORDER_CNT-1] <= LINK_W'(last_blk);
					pool_ready_q        <= 1'b1;
				end
				OP_A_HEAD:     head_q[cur_q[HEAD_W-1:0]]  <= next_rdata;
				OP_PUSH_SPLIT: head_q[cur_dn[HEAD_W-1:0]] <= LINK_W'(split_b);
				OP_PUSH_FREE:  head_q[cur_q[HEAD_W-1:0]]  <= LINK_W'(idx_q);
				OP_F_UNLINK: begin
					if (prev_rdata == NIL) begin
						head_q[cur_q[HEAD_W-1:0]] <= next_rdata;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				req_q       <= req_t'(in_type);
				req_order_q <= in_order;
				req_addr_q  <= in_addr;
			end
			OP_DECODE: begin
				sw_q  <= '0;
				cur_q <= found;
				idx_q <= (req_q == REQ_ALLOC) ? head_q[found[HEAD_W-1:0]][PAGE_W-1:0]
				                              : off[PAGE_W-1:0];
			end
			OP_SWEEP: sw_q <= sw_q + PAGE_W'(1);
			OP_PUSH_SPLIT: begin
				link_q <= old_head_dn;
				tgt_q  <= split_b;
				cur_q  <= cur_dn;
			end
			OP_PUSH_FREE: begin
				link_q <= old_head;
				tgt_q  <= idx_q;
			end
			OP_F_CHK: cur_q <= info_rdata[ORD_W-1:0];
			OP_F_BUD: tgt_q <= bud;
			OP_F_CLR: begin
				idx_q <= idx_q & tgt_q;
				cur_q <= cur_q + ORD_W'(1);
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_status_q <= cmd.code;
			out_addr_q   <= (cmd.code == ST_OK && req_q == REQ_ALLOC) ?
			                ram_base_q + (ADDR_W'(idx_q) << PAGE_SHIFT) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_addr   = out_addr_q;

endmodule

`default_nettype wire

>>> design/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller: sequences init sweep, alloc split and free merge steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl
	import bpa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire bpa_stat_t stat,
	output bpa_cmd_t       cmd
);

	typedef enum logic [14:0] {
		S_IDLE     = 15'h0001,
		S_DECODE   = 15'h0002,
		S_SWEEP    = 15'h0004,
		S_INIT_END = 15'h0008,
		S_A_HEAD   = 15'h0010,
		S_SPLIT    = 15'h0020,
		S_LINK     = 15'h0040,
		S_A_FIN    = 15'h0080,
		S_F_CHK    = 15'h0100,
		S_F_BUD    = 15'h0200,
		S_F_BCHK   = 15'h0400,
		S_F_CLR    = 15'h0800,
		S_F_PUSH   = 15'h1000,
		S_FIN      = 15'h2000,
		S_F_WAIT   = 15'h4000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd.op   = OP_NONE;
		cmd.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.op  = OP_DECODE;
				state_d = S_FIN;
				unique case (stat.req)
					REQ_INIT: begin
						if (stat.init_err) code_d = ST_NO_POOL;
						else               state_d = S_SWEEP;
					end
					REQ_ALLOC: begin
						if (!stat.pool_ready)   code_d = ST_NO_INIT;
						else if (stat.ord_bad)  code_d = ST_BAD_ORDER;
						else if (stat.none_found) code_d = ST_NO_MEM;
						else                    state_d = S_A_HEAD;
					end
					REQ_FREE: begin
						if (!stat.pool_ready)       code_d = ST_NO_INIT;
						else if (stat.misaligned)   code_d = ST_MISALIGNED;
						else if (stat.out_of_range) code_d = ST_RANGE;
						else                        state_d = S_F_CHK;
					end
					default: code_d = ST_BAD_ORDER;
				endcase
			end
			S_SWEEP: begin
				cmd.op = OP_SWEEP;
				if (stat.sweep_last) state_d = S_INIT_END;
			end
			S_INIT_END: begin
				cmd.op  = OP_INIT_END;
				code_d  = ST_OK;
				state_d = S_FIN;
			end
			S_A_HEAD: begin
				cmd.op  = OP_A_HEAD;
				state_d = stat.cur_gt_ord ? S_SPLIT : S_A_FIN;
			end
			S_SPLIT: begin
				cmd.op  = OP_PUSH_SPLIT;
				state_d = S_LINK;
			end
			S_LINK: begin
				cmd.op = OP_PUSH_LINK;
				if (stat.req == REQ_ALLOC) begin
					state_d = stat.cur_gt_ord ? S_SPLIT : S_A_FIN;
				end else begin
					code_d  = ST_OK;
					state_d = S_FIN;
				end
			end
			S_A_FIN: begin
				cmd.op  = OP_A_FIN;
				code_d  = ST_OK;
				state_d = S_FIN;
			end
			S_F_CHK: begin
				cmd.op = OP_F_CHK;
				if (stat.rd_free) begin
					code_d  = ST_ALREADY_FREE;
					state_d = S_FIN;
				end else if (!stat.rd_alloc) begin
					code_d  = ST_RESERVED;
					state_d = S_FIN;
				end else begin
					state_d = S_F_BUD;
				end
			end
			S_F_BUD: begin
				if (stat.cur_top || stat.bud_oob) begin
					state_d = S_F_PUSH;
				end else begin
					cmd.op  = OP_F_BUD;
					state_d = S_F_WAIT;
				end
			end
			S_F_WAIT: begin
				state_d = S_F_BCHK;
			end
			S_F_BCHK: begin
				if (stat.bud_match) begin
					cmd.op  = OP_F_UNLINK;
					state_d = S_F_CLR;
				end else begin
					state_d = S_F_PUSH;
				end
			end
			S_F_CLR: begin
				cmd.op  = OP_F_CLR;
				state_d = S_F_BUD;
			end
			S_F_PUSH: begin
				cmd.op  = OP_PUSH_FREE;
				state_d = S_LINK;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

`default_nettype wire

>>> design/buddy_page_allocator.sv
// Init writes one page record per cycle in the sweep over the page store.
// One item is in work at a time; the next is taken once the result is queued.
// Reset clears free-list heads, pool flag, FSM and output valid; the
// page record memories hold nothing until the first init.
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator for 4 KiB pages with init, alloc and free requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator
	import bpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [47:0]       s_axis_tdata,  // req_order[3:0], free_address[43:4]
	input  wire logic [1:0]        s_axis_tuser,  // req_type[1:0]
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [47:0]            m_axis_tdata,  // status[3:0], block_address[43:4]
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [ADDR_W-1:0] cfg_data
);

	bpa_cmd_t          cmd;
	bpa_stat_t         stat;
	logic [3:0]        out_status;
	logic [ADDR_W-1:0] out_addr;

	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	bpa_dpath u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.in_type(s_axis_tuser),
		.in_order(s_axis_tdata[ORD_W-1:0]),
		.in_addr(s_axis_tdata[ORD_W+ADDR_W-1:ORD_W]),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_status(out_status), .out_addr(out_addr)
	);

	// result packing, padded to whole bytes
	assign m_axis_tdata = {4'd0, out_addr, out_status};

endmodule

`default_nettype wire

>>> design/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_assert
// Port-level checks of the buddy page allocator result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpa_assert (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// failed requests carry a zero address
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:0] != 4'd0 |-> m_axis_tdata[43:4] == 40'd0)
		else $error("address on failed request");

	// status within the defined codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8)
		else $error("undefined status code");

	// input is not taken while a request is in work
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while busy");

endmodule

bind buddy_page_allocator bpa_assert u_bpa_assert (.*);

`default_nettype wire
